### hdl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, types and register codes for the padded tensor copy
// address generator.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // payload and register widths
  localparam int OFFSET_W   = 56;
  localparam int DATA_W     = 64;
  localparam int CFG_W      = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int DIMS_W     = 3;

  // each axis occupies one 16-bit slot of the packed registers
  localparam int FIELD_W = 16;

  // the 56-bit stride multiply is split into two 28-bit halves
  localparam int HALF_W = OFFSET_W / 2;

  // register indexes on the write port
  localparam logic [CFG_ADDR_W-1:0] REG_DIMS    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EXTENTS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LPADS   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RPADS   = 2'd3;

  // register reset values
  localparam logic [DIMS_W-1:0] DIMS_RESET    = 3'd1;
  localparam logic [CFG_W-1:0]  EXTENTS_RESET = 64'h0001_0001_0001_0001;

  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [CFG_W-1:0]    cfg_data_t;

endpackage

### hdl/ptc_stride_seq.sv
// ----------------------------------------------------------------------------
// ptc_stride_seq
// Rebuilds the per-axis target step values and the target base offset after
// reset or a register write, one multiply half-step per cycle.
// ----------------------------------------------------------------------------
module ptc_stride_seq #(
  parameter int MAX_AXES    = 4,
  parameter int EXTENT_BITS = 12,
  parameter int AXIS_W      = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  logic [AXIS_W-1:0]      last_axis,
  input  ptc_pkg::cfg_data_t     source_extents,
  input  ptc_pkg::cfg_data_t     left_pads,
  input  ptc_pkg::cfg_data_t     right_pads,
  output logic                   busy,
  output ptc_pkg::offset_t       step_delta [MAX_AXES],
  output ptc_pkg::offset_t       target_base
);
  import ptc_pkg::*;

  localparam int BW = EXTENT_BITS + 2;

  // sequencer phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_INIT  = 4'd1;
  localparam logic [3:0] PH_START = 4'd2;
  localparam logic [3:0] PH_M0    = 4'd3;
  localparam logic [3:0] PH_A0    = 4'd4;
  localparam logic [3:0] PH_M1    = 4'd5;
  localparam logic [3:0] PH_A1    = 4'd6;
  localparam logic [3:0] PH_M2    = 4'd7;
  localparam logic [3:0] PH_A2    = 4'd8;

  logic [3:0]              phase;
  logic [3:0]              phase_next;
  logic [AXIS_W-1:0]       axis;
  offset_t                 stride;
  offset_t                 span;
  offset_t                 p_lo;
  logic [HALF_W-1:0]       p_hi;
  logic [EXTENT_BITS-1:0]  ext_fld;
  logic [EXTENT_BITS-1:0]  ext;
  logic [EXTENT_BITS-1:0]  ext_m1;
  logic [EXTENT_BITS-1:0]  lp;
  logic [EXTENT_BITS-1:0]  rp;
  logic [BW-1:0]           te;
  logic [BW-1:0]           mul_b;
  logic [HALF_W+BW-1:0]    lo_prod;
  logic [HALF_W-1:0]       hi_prod;
  offset_t                 prod;

  assign busy = (phase != PH_IDLE);

  // fields of the axis being worked on
  assign ext_fld = source_extents[FIELD_W*axis +: EXTENT_BITS];
  assign ext     = (ext_fld == '0) ? EXTENT_BITS'(1) : ext_fld;
  assign ext_m1  = ext - EXTENT_BITS'(1);
  assign lp      = left_pads[FIELD_W*axis +: EXTENT_BITS];
  assign rp      = right_pads[FIELD_W*axis +: EXTENT_BITS];
  assign te      = BW'(ext) + BW'(lp) + BW'(rp);

  // multiplier operand per phase
  always_comb begin
    case (phase)
      PH_M0:   mul_b = BW'(ext_m1);
      PH_M1:   mul_b = BW'(lp);
      default: mul_b = te;
    endcase
  end

  // two half-width partial products, recombined modulo 2^56
  assign lo_prod = stride[HALF_W-1:0] * mul_b;
  assign hi_prod = stride[OFFSET_W-1:HALF_W] * mul_b;
  assign prod    = p_lo + {p_hi, {HALF_W{1'b0}}};

  // phase sequencing
  always_comb begin
    case (phase)
      PH_IDLE:  phase_next = PH_IDLE;
      PH_INIT:  phase_next = PH_START;
      PH_START: phase_next = PH_M0;
      PH_M0:    phase_next = PH_A0;
      PH_A0:    phase_next = PH_M1;
      PH_M1:    phase_next = PH_A1;
      PH_A1:    phase_next = PH_M2;
      PH_M2:    phase_next = PH_A2;
      PH_A2:    phase_next = (axis == '0) ? PH_IDLE : PH_START;
      default:  phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase <= PH_INIT;
    end else begin
      phase <= phase_next;
    end
  end

  // stride, span and base accumulation, innermost axis first
  always_ff @(posedge clk) begin
    case (phase)
      PH_INIT: begin
        axis        <= last_axis;
        stride      <= OFFSET_W'(1);
        span        <= '0;
        target_base <= '0;
      end
      PH_START: begin
        step_delta[axis] <= stride - span;
      end
      PH_M0, PH_M1, PH_M2: begin
        p_lo <= OFFSET_W'(lo_prod);
        p_hi <= hi_prod;
      end
      PH_A0: begin
        span <= span + prod;
      end
      PH_A1: begin
        target_base <= target_base + prod;
      end
      PH_A2: begin
        stride <= prod;
        if (axis != '0) begin
          axis <= axis - AXIS_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/ptc_odometer.sv
// ----------------------------------------------------------------------------
// ptc_odometer
// Per-axis index counters with running source and target offsets, stepped
// once per item.
// ----------------------------------------------------------------------------
module ptc_odometer #(
  parameter int MAX_AXES    = 4,
  parameter int EXTENT_BITS = 12,
  parameter int AXIS_W      = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   busy,
  input  logic                   step,
  input  logic [AXIS_W-1:0]      last_axis,
  input  ptc_pkg::cfg_data_t     source_extents,
  input  ptc_pkg::offset_t       step_delta [MAX_AXES],
  input  ptc_pkg::offset_t       target_base,
  output ptc_pkg::offset_t       cur_source,
  output ptc_pkg::offset_t       cur_target,
  output logic                   cur_last
);
  import ptc_pkg::*;

  logic [EXTENT_BITS-1:0] idx      [MAX_AXES];
  logic [EXTENT_BITS-1:0] idx_next [MAX_AXES];
  logic [EXTENT_BITS-1:0] ext_max  [MAX_AXES];
  logic [MAX_AXES-1:0]    wrap;
  logic                   carry;
  offset_t                delta_sel;
  offset_t                source;
  offset_t                target;

  // highest index of each axis
  for (genvar d = 0; d < MAX_AXES; d++) begin : g_axis
    logic [EXTENT_BITS-1:0] fld;
    assign fld        = source_extents[FIELD_W*d +: EXTENT_BITS];
    assign ext_max[d] = (fld == '0) ? '0 : fld - EXTENT_BITS'(1);
    assign wrap[d]    = (idx[d] >= ext_max[d]);
  end

  // ripple the carry from the innermost axis outwards
  always_comb begin
    carry     = 1'b1;
    delta_sel = '0;
    for (int d = MAX_AXES - 1; d >= 0; d--) begin
      idx_next[d] = idx[d];
      if ((AXIS_W'(d) <= last_axis) && carry) begin
        if (wrap[d]) begin
          idx_next[d] = '0;
        end else begin
          idx_next[d] = idx[d] + EXTENT_BITS'(1);
          delta_sel   = step_delta[d];
        end
        carry = wrap[d];
      end
    end
  end

  assign cur_source = source;
  assign cur_target = target;
  assign cur_last   = carry;

  // counters: cleared during a rebuild, advanced per item
  always_ff @(posedge clk) begin
    if (rst || busy) begin
      for (int d = 0; d < MAX_AXES; d++) begin
        idx[d] <= '0;
      end
      source <= '0;
      target <= target_base;
    end else if (step) begin
      idx <= idx_next;
      if (carry) begin
        source <= '0;
        target <= target_base;
      end else begin
        source <= source + OFFSET_W'(1);
        target <= target + delta_sel;
      end
    end
  end

endmodule

### hdl/padded_tensor_copy_addr_gen_core.sv
// ----------------------------------------------------------------------------
// padded_tensor_copy_addr_gen_core
// Address generator for a row-major copy of a tensor of up to four axes
// into a padded target: source offset, target offset and last flag per item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  cfg       in         cfg_we              cfg_addr, cfg_wdata
//  in        in         in_valid/in_ready   element_data
//  out       out        out_valid/out_ready src_offset, dst_offset,
//                                           element_data_out, last_element
//
//  One item per cycle when no rebuild runs and the output moves; each item
//  passes the input stage, then the result register. After reset and after
//  every register write the step table is rebuilt by a shared two-half
//  multiplier, with in_ready low. A stalled output holds; one more item waits
//  in the input stage, then in_ready drops until the output moves.
// ----------------------------------------------------------------------------
module padded_tensor_copy_addr_gen_core #(
  parameter int MAX_AXES    = 4,
  parameter int EXTENT_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ptc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  ptc_pkg::cfg_data_t                  cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ptc_pkg::data_t                      element_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ptc_pkg::offset_t                    src_offset,
  output ptc_pkg::offset_t                    dst_offset,
  output ptc_pkg::data_t                      element_data_out,
  output logic                                last_element
);
  import ptc_pkg::*;

  localparam int AXIS_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

  logic [DIMS_W-1:0] dims_in_use;
  cfg_data_t         source_extents;
  cfg_data_t         left_pads;
  cfg_data_t         right_pads;
  logic [DIMS_W-1:0] dims_eff;
  logic [AXIS_W-1:0] last_axis;
  logic              busy;
  offset_t           step_delta [MAX_AXES];
  offset_t           target_base;
  offset_t           cur_source;
  offset_t           cur_target;
  logic              cur_last;
  logic              s1_valid;
  data_t             s1_data;
  logic              advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use    <= DIMS_RESET;
      source_extents <= EXTENTS_RESET;
      left_pads      <= '0;
      right_pads     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DIMS:    dims_in_use    <= cfg_wdata[DIMS_W-1:0];
        REG_EXTENTS: source_extents <= cfg_wdata;
        REG_LPADS:   left_pads      <= cfg_wdata;
        REG_RPADS:   right_pads     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // axis count clamped to one .. MAX_AXES
  always_comb begin
    dims_eff = dims_in_use;
    if (dims_eff == '0) begin
      dims_eff = DIMS_W'(1);
    end
    if (dims_eff > DIMS_W'(MAX_AXES)) begin
      dims_eff = DIMS_W'(MAX_AXES);
    end
  end
  assign last_axis = AXIS_W'(dims_eff - DIMS_W'(1));

  ptc_stride_seq #(
    .MAX_AXES    (MAX_AXES),
    .EXTENT_BITS (EXTENT_BITS),
    .AXIS_W      (AXIS_W)
  ) u_stride_seq (
    .clk            (clk),
    .rst            (rst),
    .restart        (cfg_we),
    .last_axis      (last_axis),
    .source_extents (source_extents),
    .left_pads      (left_pads),
    .right_pads     (right_pads),
    .busy           (busy),
    .step_delta     (step_delta),
    .target_base    (target_base)
  );

  ptc_odometer #(
    .MAX_AXES    (MAX_AXES),
    .EXTENT_BITS (EXTENT_BITS),
    .AXIS_W      (AXIS_W)
  ) u_odometer (
    .clk            (clk),
    .rst            (rst),
    .busy           (busy),
    .step           (advance),
    .last_axis      (last_axis),
    .source_extents (source_extents),
    .step_delta     (step_delta),
    .target_base    (target_base),
    .cur_source     (cur_source),
    .cur_target     (cur_target),
    .cur_last       (cur_last)
  );

  // handshake between input stage and result register
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !busy && (!s1_valid || advance);

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= element_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      src_offset       <= cur_source;
      dst_offset       <= cur_target;
      element_data_out <= s1_data;
      last_element     <= cur_last;
    end
  end

endmodule

### hdl/ptc_checker.sv
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the padded tensor copy address generator, bound to
// the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                in_ready,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  ptc_pkg::offset_t                    src_offset,
  input  ptc_pkg::offset_t                    dst_offset,
  input  ptc_pkg::data_t                      element_data_out,
  input  logic                                last_element
);
  import ptc_pkg::*;

  logic    prev_last;
  offset_t prev_source;

  // last delivered source offset; a new copy starts after reset or a write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      prev_last <= 1'b1;
    end else if (out_valid && out_ready) begin
      prev_last   <= last_element;
      prev_source <= src_offset;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(src_offset)
      && $stable(dst_offset) && $stable(element_data_out) && $stable(last_element))
    else $error("result changed while stalled");

  // no item taken in the cycle after reset
  a_rst_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("in_ready high straight after reset");

  // a register write starts a rebuild
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("in_ready high straight after a register write");

  // source offsets count up and return to zero after the last item
  a_src_seq: assert property (@(posedge clk) disable iff (rst || cfg_we)
    out_valid && out_ready |->
      src_offset == (prev_last ? '0 : prev_source + OFFSET_W'(1)))
    else $error("source offset out of sequence");

endmodule

bind padded_tensor_copy_addr_gen_core ptc_checker u_checker (.*);
